// File: hdl/rrs_pkg.sv
// Round-robin scheduler package: item structs, result codes and the
// command/status bundles between controller and datapath.
// No dependencies.
package rrs_pkg;

    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int STAT_W  = 3;
    localparam int SLOT_W  = 4;
    localparam int RUN_W   = 8;
    localparam int TIME_W  = 21;
    localparam int QUANT_W = 8;

    localparam logic [TIME_W-1:0]  TIME_MAX      = 21'h1F_FFFF;
    localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd4;

    // action codes
    localparam logic ACT_LOAD     = 1'b0;
    localparam logic ACT_DISPATCH = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_LOADED = 3'd0;
    localparam logic [STAT_W-1:0] ST_RUN    = 3'd1;
    localparam logic [STAT_W-1:0] ST_IDLE   = 3'd2;
    localparam logic [STAT_W-1:0] ST_DONE   = 3'd3;
    localparam logic [STAT_W-1:0] ST_REJECT = 3'd4;

    typedef struct packed {
        logic               action;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst_length;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [RUN_W-1:0]  run_length;
        logic [TIME_W-1:0] start_time;
        logic              finished;
        logic [TIME_W-1:0] turnaround;
    } out_item_t;

    typedef struct packed {
        logic latch_in;     // capture accepted item
        logic load;         // apply load item
        logic all_done;     // nothing left to run
        logic admit_start;  // admission limit := current time
        logic adm_rd;       // read arrival at admit pointer
        logic adm_push;     // queue admit pointer
        logic idle;         // idle tick
        logic pop;          // read queue head
        logic slot_rd;      // read stores at popped slot
        logic run;          // compute slice
        logic post;         // requeue or retire, build result
        logic emit;         // move result to output register
    } dp_cmd_t;

    typedef struct packed {
        logic action;
        logic all_done;
        logic adm_more;
        logic adm_hit;
        logic fifo_empty;
        logic out_free;
    } dp_status_t;

endpackage

// File: hdl/rrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/rrs_ctrl.sv
// Round-robin scheduler controller: sequences load, admission, slice and
// result steps. Depends on rrs_pkg.
module rrs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rrs_pkg::dp_status_t st,
    output rrs_pkg::dp_cmd_t    cmd
);
    import rrs_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_ADM_RD  = 4'd2;
    localparam logic [3:0] S_ADM_CHK = 4'd3;
    localparam logic [3:0] S_POP     = 4'd4;
    localparam logic [3:0] S_SLOT    = 4'd5;
    localparam logic [3:0] S_RUN     = 4'd6;
    localparam logic [3:0] S_POST    = 4'd7;
    localparam logic [3:0] S_FIN     = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       phase_reg, phase_next;   // 0: before slice, 1: after slice
    logic [3:0] adm_exit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // no item is taken while reset is held
    assign s_ready = aresetn && (state_reg == S_IDLE);

    // where admission goes once no more pending process qualifies
    always_comb begin
        if (phase_reg) begin
            adm_exit = S_POST;
        end else if (st.fifo_empty) begin
            adm_exit = S_FIN;
        end else begin
            adm_exit = S_POP;
        end
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                if (st.action == ACT_LOAD) begin
                    cmd.load   = 1'b1;
                    state_next = S_FIN;
                end else if (st.all_done) begin
                    cmd.all_done = 1'b1;
                    state_next   = S_FIN;
                end else begin
                    cmd.admit_start = 1'b1;
                    phase_next      = 1'b0;
                    state_next      = S_ADM_RD;
                end
            end
            S_ADM_RD: begin
                if (st.adm_more) begin
                    cmd.adm_rd = 1'b1;
                    state_next = S_ADM_CHK;
                end else begin
                    cmd.idle   = !phase_reg && st.fifo_empty;
                    state_next = adm_exit;
                end
            end
            S_ADM_CHK: begin
                if (st.adm_hit) begin
                    cmd.adm_push = 1'b1;
                    state_next   = S_ADM_RD;
                end else begin
                    cmd.idle   = !phase_reg && st.fifo_empty;
                    state_next = adm_exit;
                end
            end
            S_POP: begin
                cmd.pop    = 1'b1;
                state_next = S_SLOT;
            end
            S_SLOT: begin
                cmd.slot_rd = 1'b1;
                state_next  = S_RUN;
            end
            S_RUN: begin
                cmd.run    = 1'b1;
                phase_next = 1'b1;
                state_next = S_ADM_RD;
            end
            S_POST: begin
                cmd.post   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/rrs_datapath.sv
// Round-robin scheduler datapath: process stores, ready queue, counters,
// time keeping and the output register. Depends on rrs_pkg and rrs_ram.
module rrs_datapath #(
    parameter int MAX_PROCESSES = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rrs_pkg::in_item_t             s_item,
    input  logic                          cfg_we,
    input  logic [rrs_pkg::QUANT_W-1:0]   cfg_wdata,
    input  rrs_pkg::dp_cmd_t              cmd,
    output rrs_pkg::dp_status_t           st,
    output logic                          m_valid,
    input  logic                          m_ready,
    output rrs_pkg::out_item_t            m_item
);
    import rrs_pkg::*;

    localparam int IDX_W = $clog2(MAX_PROCESSES);
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PROCESSES - 1);
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_PROCESSES);

    in_item_t            in_reg;
    logic [QUANT_W-1:0]  quantum_reg;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [TIME_W-1:0]   limit_reg;          // admission limit, slice end after run
    logic [CNT_W-1:0]    loaded_reg, admit_reg, completed_reg, count_reg;
    logic [IDX_W-1:0]    head_reg, tail_reg;
    logic [ARR_W-1:0]    last_arr_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic [RUN_W-1:0]    run_reg;
    logic [TIME_W-1:0]   start_reg;
    logic [BURST_W-1:0]  rem_left_reg;
    logic [ARR_W-1:0]    arr_slot_reg;
    out_item_t           stage_reg, stage_next;
    out_item_t           m_item_reg;
    logic                m_valid_reg;

    logic [ARR_W-1:0]    arr_rd;
    logic [BURST_W-1:0]  rem_rd;
    logic [IDX_W-1:0]    fifo_rd;
    logic [IDX_W-1:0]    load_idx, admit_idx;
    logic [IDX_W-1:0]    arr_raddr;
    logic                arr_re, arr_we;
    logic                rem_we;
    logic [IDX_W-1:0]    rem_waddr;
    logic [BURST_W-1:0]  rem_wdata;
    logic                fifo_we;
    logic [IDX_W-1:0]    fifo_wdata;
    logic [QUANT_W-1:0]  q_eff;
    logic [RUN_W-1:0]    run_calc;
    logic [TIME_W:0]     end_sum;
    logic [TIME_W-1:0]   end_calc;
    logic [TIME_W-1:0]   ta_calc;
    logic                load_ok;
    logic                requeue;

    assign load_idx  = loaded_reg[IDX_W-1:0];
    assign admit_idx = admit_reg[IDX_W-1:0];

    assign load_ok = (loaded_reg < MAX_CNT) && (in_reg.burst_length != '0) &&
                     !((loaded_reg != '0) && (in_reg.arrival < last_arr_reg));

    assign q_eff    = (quantum_reg == '0) ? QUANT_W'(1) : quantum_reg;
    assign run_calc = (rem_rd < BURST_W'(q_eff)) ? rem_rd[RUN_W-1:0] : q_eff;
    assign end_sum  = {1'b0, time_reg} + (TIME_W + 1)'(run_calc);
    assign end_calc = (end_sum > {1'b0, TIME_MAX}) ? TIME_MAX : end_sum[TIME_W-1:0];
    assign ta_calc  = (limit_reg >= TIME_W'(arr_slot_reg)) ?
                      limit_reg - TIME_W'(arr_slot_reg) : '0;
    assign requeue  = (rem_left_reg != '0);

    // memories
    assign arr_we    = cmd.load && load_ok;
    assign arr_re    = cmd.adm_rd || cmd.slot_rd;
    assign arr_raddr = cmd.slot_rd ? fifo_rd : admit_idx;

    assign rem_we    = arr_we || cmd.run;
    assign rem_waddr = cmd.run ? slot_reg : load_idx;
    assign rem_wdata = cmd.run ? rem_rd - BURST_W'(run_calc) : in_reg.burst_length;

    assign fifo_we    = cmd.adm_push || (cmd.post && requeue);
    assign fifo_wdata = cmd.post ? slot_reg : admit_idx;

    rrs_ram #(.WIDTH(ARR_W), .DEPTH(MAX_PROCESSES)) u_arrival_ram (
        .aclk  (aclk),
        .we    (arr_we),
        .waddr (load_idx),
        .wdata (in_reg.arrival),
        .re    (arr_re),
        .raddr (arr_raddr),
        .rdata (arr_rd)
    );

    rrs_ram #(.WIDTH(BURST_W), .DEPTH(MAX_PROCESSES)) u_remaining_ram (
        .aclk  (aclk),
        .we    (rem_we),
        .waddr (rem_waddr),
        .wdata (rem_wdata),
        .re    (cmd.slot_rd),
        .raddr (fifo_rd),
        .rdata (rem_rd)
    );

    rrs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PROCESSES)) u_ready_fifo_ram (
        .aclk  (aclk),
        .we    (fifo_we),
        .waddr (tail_reg),
        .wdata (fifo_wdata),
        .re    (cmd.pop),
        .raddr (head_reg),
        .rdata (fifo_rd)
    );

    // current time
    always_comb begin
        time_next = time_reg;
        if (cmd.idle) begin
            if (time_reg != TIME_MAX) begin
                time_next = time_reg + TIME_W'(1);
            end
        end else if (cmd.post) begin
            time_next = limit_reg;
        end
    end

    // result staging
    always_comb begin
        stage_next = stage_reg;
        if (cmd.load) begin
            stage_next = '0;
            if (load_ok) begin
                stage_next.status = ST_LOADED;
                stage_next.slot   = SLOT_W'(load_idx);
            end else begin
                stage_next.status = ST_REJECT;
            end
        end else if (cmd.all_done || cmd.idle) begin
            stage_next            = '0;
            stage_next.status     = cmd.idle ? ST_IDLE : ST_DONE;
            stage_next.start_time = time_reg;
        end else if (cmd.post) begin
            stage_next.status     = ST_RUN;
            stage_next.slot       = SLOT_W'(slot_reg);
            stage_next.run_length = run_reg;
            stage_next.start_time = start_reg;
            stage_next.finished   = !requeue;
            stage_next.turnaround = requeue ? '0 : ta_calc;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg   <= QUANTUM_RESET;
            time_reg      <= '0;
            loaded_reg    <= '0;
            admit_reg     <= '0;
            completed_reg <= '0;
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                quantum_reg <= cfg_wdata;
            end
            time_reg <= time_next;
            if (arr_we) begin
                loaded_reg <= loaded_reg + CNT_W'(1);
            end
            if (cmd.adm_push) begin
                admit_reg <= admit_reg + CNT_W'(1);
            end
            if (cmd.post && !requeue) begin
                completed_reg <= completed_reg + CNT_W'(1);
            end
            // push and pop never fall in the same cycle
            if (fifo_we) begin
                count_reg <= count_reg + CNT_W'(1);
                tail_reg  <= (tail_reg == LAST_IDX) ? '0 : tail_reg + IDX_W'(1);
            end else if (cmd.pop) begin
                count_reg <= count_reg - CNT_W'(1);
                head_reg  <= (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            in_reg <= s_item;
        end
        if (arr_we) begin
            last_arr_reg <= in_reg.arrival;
        end
        if (cmd.admit_start) begin
            limit_reg <= time_reg;
        end else if (cmd.run) begin
            limit_reg <= end_calc;
        end
        if (cmd.slot_rd) begin
            slot_reg <= fifo_rd;
        end
        if (cmd.run) begin
            run_reg      <= run_calc;
            start_reg    <= time_reg;
            rem_left_reg <= rem_rd - BURST_W'(run_calc);
            arr_slot_reg <= arr_rd;
        end
        stage_reg <= stage_next;
        if (cmd.emit) begin
            m_item_reg <= stage_reg;
        end
    end

    assign st.action     = in_reg.action;
    assign st.all_done   = (completed_reg >= loaded_reg);
    assign st.adm_more   = (admit_reg < loaded_reg);
    assign st.adm_hit    = (TIME_W'(arr_rd) <= limit_reg);
    assign st.fifo_empty = (count_reg == '0);
    assign st.out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// File: hdl/round_robin_cpu_scheduler_core.sv
// Round-robin CPU scheduler with time quantum, top level.
// Depends on rrs_pkg, rrs_ctrl, rrs_datapath (and through it rrs_ram).
//
// One item is handled at a time. A dispatch that runs a slice takes longer
// for every pending process it admits to the ready queue: admission walks
// the arrival memory one entry per read through its single read port. A
// result still waiting for m_ready holds the next one back until it goes.
// A new item is taken as soon as the previous one has been placed in the
// output register, even while that result still waits for m_ready.
// time_quantum may be written at any idle moment through cfg_we/cfg_wdata;
// a quantum of zero acts as one.
module round_robin_cpu_scheduler_core #(
    parameter int MAX_PROCESSES = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  rrs_pkg::in_item_t           s_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output rrs_pkg::out_item_t          m_item,
    input  logic                        cfg_we,
    input  logic [rrs_pkg::QUANT_W-1:0] cfg_wdata
);
    import rrs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t st;

    rrs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    rrs_datapath #(.MAX_PROCESSES(MAX_PROCESSES)) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .st        (st),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

// File: hdl/rrs_checker.sv
// Port-level checks for the round-robin scheduler, bound to the top level.
// Depends on rrs_pkg and round_robin_cpu_scheduler_core.
module rrs_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input rrs_pkg::in_item_t  s_item,
    input logic               m_valid,
    input logic               m_ready,
    input rrs_pkg::out_item_t m_item
);
    import rrs_pkg::*;

    // a held result keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // one item at a time: no accept straight after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted while busy");

    a_finished_only_on_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.finished |-> m_item.status == ST_RUN)
        else $error("finished flag outside a slice");

    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status == ST_REJECT |->
            m_item.slot == '0 && m_item.run_length == '0 &&
            m_item.start_time == '0 && m_item.turnaround == '0)
        else $error("rejected load carries data");

    a_turnaround_needs_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.finished |-> m_item.turnaround == '0)
        else $error("turnaround without completion");

endmodule

bind round_robin_cpu_scheduler_core rrs_checker u_rrs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

// File: test/round_robin_cpu_scheduler_core_test.sv
// Self-checking testbench for round_robin_cpu_scheduler_core: a directed table and then
// random load/dispatch traffic, with every result checked against a fixed table entry or
// a round-robin scheduler model. Depends on rrs_pkg and the core.
module round_robin_cpu_scheduler_core_test;
    import rrs_pkg::*;

    localparam int MAX_PROC    = 16;
    localparam int LONG_SLOT   = 9;       // this table slot gets the longest burst
    localparam int DIR_ROWS    = 24;
    localparam int PHASE_ITEMS = 360;
    localparam int CYCLE_LIMIT = 1_500_000;

    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } step_row_t;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;
    logic      cfg_we;
    logic [QUANT_W-1:0] cfg_wdata;

    // scheduler model state
    logic [ARR_W-1:0]   arr_tab    [MAX_PROC];
    logic [BURST_W-1:0] left_tab   [MAX_PROC];
    logic [SLOT_W-1:0]  ready_ring [MAX_PROC];
    int unsigned        ring_head, ring_len, n_loaded, n_admitted, n_done;
    logic [TIME_W-1:0]  now;
    logic [QUANT_W-1:0] quantum;

    out_item_t queued_reports [$];
    step_row_t dir_rows [DIR_ROWS];
    bit        stalls_enabled = 1'b1;
    int        mismatch_count = 0;
    int        cycle_count = 0;

    round_robin_cpu_scheduler_core #(
        .MAX_PROCESSES(MAX_PROC)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("round_robin_cpu_scheduler_core_test NOT OK");
            $finish;
        end
    end

    function automatic void push_ready(input int unsigned slot);
        ready_ring[(ring_head + ring_len) % MAX_PROC] = SLOT_W'(slot);
        ring_len++;
    endfunction

    function automatic void admit_arrivals(input int unsigned limit);
        while (n_admitted < n_loaded && arr_tab[n_admitted] <= limit) begin
            push_ready(n_admitted);
            n_admitted++;
        end
    endfunction

    function automatic out_item_t schedule_step(input in_item_t it);
        out_item_t   r;
        int unsigned slot, q, run, start, fin_time;
        r = '0;
        if (it.action == ACT_LOAD) begin
            if (n_loaded >= MAX_PROC || it.burst_length == 0 ||
                (n_loaded > 0 && it.arrival < arr_tab[n_loaded - 1])) begin
                r.status = ST_REJECT;
            end else begin
                arr_tab[n_loaded]  = it.arrival;
                left_tab[n_loaded] = it.burst_length;
                r.status = ST_LOADED;
                r.slot   = SLOT_W'(n_loaded);
                n_loaded++;
            end
            return r;
        end
        if (n_done >= n_loaded) begin
            r.status     = ST_DONE;
            r.start_time = now;
            return r;
        end
        admit_arrivals(now);
        if (ring_len == 0) begin
            r.status     = ST_IDLE;
            r.start_time = now;
            if (now != TIME_MAX)
                now = now + TIME_W'(1);
            return r;
        end
        slot      = ready_ring[ring_head];
        ring_head = (ring_head + 1) % MAX_PROC;
        ring_len--;
        q        = (quantum == 0) ? 1 : quantum;
        run      = (left_tab[slot] < q) ? left_tab[slot] : q;
        start    = now;
        fin_time = start + run;
        if (fin_time > TIME_MAX)
            fin_time = TIME_MAX;
        left_tab[slot] = BURST_W'(left_tab[slot] - run);
        // arrivals during the slice queue ahead of the preempted process
        admit_arrivals(fin_time);
        now          = TIME_W'(fin_time);
        r.status     = ST_RUN;
        r.slot       = SLOT_W'(slot);
        r.run_length = RUN_W'(run);
        r.start_time = TIME_W'(start);
        if (left_tab[slot] != 0) begin
            push_ready(slot);
        end else begin
            n_done++;
            r.finished   = 1'b1;
            r.turnaround = (fin_time >= arr_tab[slot]) ?
                           TIME_W'(fin_time - arr_tab[slot]) : '0;
        end
        return r;
    endfunction

    function automatic step_row_t row(input logic act, input int arr, input int burst,
                                      input logic typed, input logic [STAT_W-1:0] st,
                                      input int slot, input int start);
        step_row_t r;
        r = '0;
        r.item.action       = act;
        r.item.arrival      = ARR_W'(arr);
        r.item.burst_length = BURST_W'(burst);
        r.typed             = typed;
        r.want.status       = st;
        r.want.slot         = SLOT_W'(slot);
        r.want.start_time   = TIME_W'(start);
        return r;
    endfunction

    function automatic in_item_t dispatch_item();
        in_item_t it;
        it.action       = ACT_DISPATCH;
        it.arrival      = ARR_W'($urandom);
        it.burst_length = BURST_W'($urandom);
        return it;
    endfunction

    function automatic in_item_t next_load();
        in_item_t    it;
        int unsigned last, pick, arr;
        it.action       = ACT_LOAD;
        it.arrival      = ARR_W'($urandom);
        it.burst_length = BURST_W'($urandom);
        if (n_loaded >= MAX_PROC)
            return it;
        last = (n_loaded == 0) ? 0 : arr_tab[n_loaded - 1];
        pick = $urandom_range(0, 19);
        if (pick == 0 && last > 0) begin
            it.arrival = ARR_W'($urandom_range(0, last - 1));
            return it;
        end
        arr = last + (($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 60));
        if (arr > 65534)
            arr = 65534;
        // the last slot arrives at the top of the range
        it.arrival = (n_loaded == MAX_PROC - 1) ? '1 : ARR_W'(arr);
        if (pick == 1)
            it.burst_length = '0;
        else if (n_loaded == LONG_SLOT)
            it.burst_length = '1;
        else if (pick < 15)
            it.burst_length = BURST_W'($urandom_range(1, 40));
        else if (pick < 19)
            it.burst_length = BURST_W'($urandom_range(41, 2000));
        else
            it.burst_length = BURST_W'($urandom_range(1, 65535));
        return it;
    endfunction

    function automatic in_item_t next_random_item();
        if (n_loaded < MAX_PROC ? $urandom_range(0, 89) == 0 : $urandom_range(0, 9) == 0)
            return next_load();
        return dispatch_item();
    endfunction

    task automatic offer_item(input in_item_t it, input logic typed, input out_item_t fixed);
        out_item_t predicted;
        if (stalls_enabled && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predicted = schedule_step(it);
        queued_reports.insert(queued_reports.size(), typed ? fixed : predicted);
    endtask

    task automatic set_quantum(input logic [QUANT_W-1:0] q);
        s_valid <= 1'b0;
        while (queued_reports.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= q;
        @(posedge aclk);
        cfg_we  <= 1'b0;
        quantum = q;
    endtask

    task automatic report(input string name, input logic [TIME_W-1:0] want_v,
                          input logic [TIME_W-1:0] got_v);
        $display("%0t: %s expected %0d, actual %0d", $time, name, want_v, got_v);
        mismatch_count++;
    endtask

    task automatic check_result(input out_item_t want, input out_item_t got);
        if (got.status !== want.status)
            report("status", TIME_W'(want.status), TIME_W'(got.status));
        if (got.slot !== want.slot)
            report("slot", TIME_W'(want.slot), TIME_W'(got.slot));
        if (got.run_length !== want.run_length)
            report("run_length", TIME_W'(want.run_length), TIME_W'(got.run_length));
        if (got.start_time !== want.start_time)
            report("start_time", want.start_time, got.start_time);
        if (got.finished !== want.finished)
            report("finished", TIME_W'(want.finished), TIME_W'(got.finished));
        if (got.turnaround !== want.turnaround)
            report("turnaround", want.turnaround, got.turnaround);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (queued_reports.size() == 0) begin
                $display("%0t: result expected none, actual %h", $time, m_item);
                mismatch_count++;
            end else begin
                check_result(queued_reports.pop_front(), m_item);
            end
        end
    end

    initial begin : result_sink
        forever begin
            if (stalls_enabled && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    initial begin : stimulus
        logic [QUANT_W-1:0] phase_quanta [5];
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_item    <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        ring_head  = 0;
        ring_len   = 0;
        n_loaded   = 0;
        n_admitted = 0;
        n_done     = 0;
        now        = '0;
        quantum    = QUANTUM_RESET;

        dir_rows[0]  = row(ACT_DISPATCH, 0, 0, 1'b1, ST_DONE, 0, 0);     // nothing loaded
        dir_rows[1]  = row(ACT_LOAD, 65535, 0, 1'b1, ST_REJECT, 0, 0);   // zero burst
        dir_rows[2]  = row(ACT_LOAD, 2, 6, 1'b1, ST_LOADED, 0, 0);
        dir_rows[3]  = row(ACT_LOAD, 0, 65535, 1'b1, ST_REJECT, 0, 0);   // arrives too early
        dir_rows[4]  = row(ACT_LOAD, 2, 1, 1'b1, ST_LOADED, 1, 0);       // same arrival
        dir_rows[5]  = row(ACT_DISPATCH, 0, 0, 1'b1, ST_IDLE, 0, 0);
        dir_rows[6]  = row(ACT_DISPATCH, 0, 0, 1'b1, ST_IDLE, 0, 1);
        dir_rows[7]  = row(ACT_DISPATCH, 0, 0, 1'b0, ST_RUN, 0, 0);
        dir_rows[8]  = row(ACT_LOAD, 3, 9, 1'b1, ST_LOADED, 2, 0);       // late load
        for (int i = 9; i < 16; i++)
            dir_rows[i] = row(ACT_DISPATCH, 0, 0, 1'b0, ST_RUN, 0, 0);
        dir_rows[16] = row(ACT_LOAD, 30, 3, 1'b1, ST_LOADED, 3, 0);      // arrives in future
        dir_rows[17] = row(ACT_LOAD, 29, 5, 1'b1, ST_REJECT, 0, 0);
        dir_rows[18] = row(ACT_LOAD, 30, 255, 1'b1, ST_LOADED, 4, 0);
        for (int i = 19; i < DIR_ROWS; i++)
            dir_rows[i] = row(ACT_DISPATCH, 0, 0, 1'b0, ST_RUN, 0, 0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            offer_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        // zero quantum behaves as one
        phase_quanta[0] = 8'd0;
        phase_quanta[1] = 8'd1;
        phase_quanta[2] = 8'd255;
        phase_quanta[3] = QUANT_W'($urandom_range(2, 254));
        phase_quanta[4] = 8'd17;
        for (int p = 0; p < 5; p++) begin
            set_quantum(phase_quanta[p]);
            repeat (PHASE_ITEMS)
                offer_item(next_random_item(), 1'b0, '0);
        end

        // last part: no stalls, fill the table, drain it, then poke the finished block
        set_quantum(8'd255);
        stalls_enabled = 1'b0;
        while (n_loaded < MAX_PROC)
            offer_item(next_load(), 1'b0, '0);
        while (n_done < n_loaded)
            offer_item(dispatch_item(), 1'b0, '0);
        repeat (40)
            offer_item(next_random_item(), 1'b0, '0);

        s_valid <= 1'b0;
        while (queued_reports.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("round_robin_cpu_scheduler_core_test OK");
        else
            $display("round_robin_cpu_scheduler_core_test NOT OK");
        $finish;
    end

endmodule
